/* design/free_list_page_allocator_macros.svh */
// Assertion macros for the free list page allocator.
// Used by fpa_ctrl; expects i_clk and i_rst_n in the including scope.
`ifndef FREE_LIST_PAGE_ALLOCATOR_MACROS_SVH
`define FREE_LIST_PAGE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FPA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fpa assertion failed");

// next-cycle implication
`define FPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fpa assertion failed");

`endif

/* design/fpa_pkg.sv */
// Package for the free list page allocator: sizes, codes and shared types.
// No dependencies.
package fpa_pkg;

    localparam int PAGE_COUNT = 64;
    localparam int PAGE_BYTES = 4096;
    localparam int ADDR_W     = 32;
    localparam int STS_W      = 3;
    localparam int IDX_W      = $clog2(PAGE_COUNT);
    localparam int PTR_W      = $clog2(PAGE_COUNT + 1);
    localparam int OFS_W      = $clog2(PAGE_BYTES);
    localparam logic [ADDR_W-1:0] POOL_BYTES = ADDR_W'(PAGE_COUNT * PAGE_BYTES);

    typedef enum logic [1:0] {
        REQ_ALLOC_PAGE  = 2'd0,
        REQ_ALLOC_STACK = 2'd1,
        REQ_FREE_PAGE   = 2'd2,
        REQ_FREE_STACK  = 2'd3
    } t_req;

    typedef enum logic [STS_W-1:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_CORRUPT    = 3'd2,
        ST_OUTSIDE    = 3'd3,
        ST_MISALIGNED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    typedef struct packed {
        logic load;   // capture request, read next-index table at head
        logic exec;   // apply request, load result register
    } t_dp_cmd;

endpackage

/* design/fpa_dp.sv */
// Datapath: pool base, head pointer, free bits, next-index memory, result register.
// Depends on fpa_pkg; driven by fpa_ctrl commands.
module fpa_dp import fpa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic                i_cfg_we,
    input  logic [ADDR_W-1:0]   i_cfg_wdata,
    input  logic [1:0]          i_req_type,
    input  logic [ADDR_W-1:0]   i_addr,
    output logic [ADDR_W-1:0]   o_result_addr,
    output logic [STS_W-1:0]    o_status
);

    logic [ADDR_W-1:0]     r_base;
    logic [PTR_W-1:0]      r_head;
    logic [PAGE_COUNT-1:0] r_free;
    logic [PAGE_COUNT-1:0] r_nx_valid;
    logic [PTR_W-1:0]      r_mem [PAGE_COUNT];
    logic [PTR_W-1:0]      r_rd_data;
    logic                  r_rd_valid;
    t_req                  r_req;
    logic [ADDR_W-1:0]     r_addr;
    logic [ADDR_W-1:0]     r_result;
    t_status               r_status;

    logic [IDX_W-1:0]  head_pg;
    logic [PTR_W-1:0]  head_next;
    logic [ADDR_W-1:0] off;
    logic [IDX_W-1:0]  free_pg;
    logic [ADDR_W-1:0] alloc_addr;
    logic              alloc_ok;
    logic              free_ok;
    t_status           n_status;
    logic [ADDR_W-1:0] n_result;

    assign head_pg    = r_head[IDX_W-1:0];
    assign head_next  = r_rd_valid ? r_rd_data : r_head + PTR_W'(1);
    assign off        = r_addr - r_base;
    assign free_pg    = off[OFS_W+IDX_W-1:OFS_W];
    assign alloc_addr = r_base + ((ADDR_W'(r_head) +
                        ADDR_W'(r_req == REQ_ALLOC_STACK)) << OFS_W);

    always_comb begin
        alloc_ok = 1'b0;
        free_ok  = 1'b0;
        n_result = '0;
        n_status = ST_OK;
        unique case (r_req)
            REQ_ALLOC_PAGE, REQ_ALLOC_STACK: begin
                if (r_head >= PTR_W'(PAGE_COUNT)) begin
                    n_status = ST_EMPTY;
                end else if (!r_free[head_pg]) begin
                    n_status = ST_CORRUPT;
                end else begin
                    alloc_ok = 1'b1;
                    n_result = alloc_addr;
                end
            end
            REQ_FREE_PAGE, REQ_FREE_STACK: begin
                if (off >= POOL_BYTES) begin
                    n_status = ST_OUTSIDE;
                end else if (off[OFS_W-1:0] != '0) begin
                    n_status = ST_MISALIGNED;
                end else begin
                    free_ok = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= '0;
            r_head     <= '0;
            r_free     <= '1;
            r_nx_valid <= '0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (i_cmd.exec && alloc_ok) begin
                r_head          <= head_next;
                r_free[head_pg] <= 1'b0;
            end else if (i_cmd.exec && free_ok) begin
                r_head              <= PTR_W'(free_pg);
                r_free[free_pg]     <= 1'b1;
                r_nx_valid[free_pg] <= 1'b1;
            end
        end
    end

    // next-index memory: unwritten entries read as index plus one
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && free_ok) begin
            r_mem[free_pg] <= r_head;
        end
        if (i_cmd.load) begin
            r_rd_data  <= r_mem[head_pg];
            r_rd_valid <= r_nx_valid[head_pg];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= t_req'(i_req_type);
            r_addr <= (t_req'(i_req_type) == REQ_FREE_STACK) ?
                      i_addr - ADDR_W'(PAGE_BYTES) : i_addr;
        end
        if (i_cmd.exec) begin
            r_result <= n_result;
            r_status <= n_status;
        end
    end

    assign o_result_addr = r_result;
    assign o_status      = r_status;

endmodule

/* design/fpa_ctrl.sv */
// Controller: request sequencing and both channel handshakes.
// Depends on fpa_pkg and free_list_page_allocator_macros.svh.
`include "free_list_page_allocator_macros.svh"
module fpa_ctrl import fpa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd.load = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec = (r_state == S_EXEC) && out_free;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `FPA_ASSERT_NEXT(a_load_to_exec, o_cmd.load, r_state == S_EXEC)
    `FPA_ASSERT_NEXT(a_exec_gives_result, o_cmd.exec, r_out_valid && r_state == S_IDLE)
    `FPA_ASSERT_NOW(a_no_overwrite, o_cmd.exec, !r_out_valid || !i_out_stall)
    `FPA_ASSERT_NEXT(a_held_result_waits,
        r_state == S_EXEC && r_out_valid && i_out_stall, r_state == S_EXEC)

endmodule

/* design/free_list_page_allocator.sv */
// Top level of the free list page allocator; joins fpa_ctrl and fpa_dp.
// Depends on fpa_pkg.
// A pool of 64 pages of 4096 bytes starting at the pool base is kept as a last-in first-out
// free list. Each request gives exactly one result, with one request in flight: a new request
// is not taken until the last one has been executed into the output register. Between the
// input transfer and the result lies the registered read of the next-index memory at the
// head page. A finished result waits in the output register while the next request is taken.
// Write the pool base only while no request is in flight.
module free_list_page_allocator import fpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_req_type,
    input  logic [ADDR_W-1:0] i_addr,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ADDR_W-1:0] o_result_addr,
    output logic [STS_W-1:0]  o_status
);

    t_dp_cmd cmd;

    fpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    fpa_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_type    (i_req_type),
        .i_addr        (i_addr),
        .o_result_addr (o_result_addr),
        .o_status      (o_status)
    );

endmodule
